FILE: hw/rtl/assert_macros.svh
// Assertion helpers for the deque. Every check samples on the rising edge of
// clk_i and is switched off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define DQS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define DQS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define DQS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/dqs_pkg.sv
package dqs_pkg;

  localparam int DEPTH     = 16;
  localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int DATA_W    = 32;
  localparam int ACT_W     = 3;
  localparam int STATUS_W  = 3;
  localparam int POS_W     = 4;
  localparam int CNT_OUT_W = 5;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_CLEAR      = 3'd4,
    ACT_SEARCH     = 3'd5
  } act_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK       = 3'd0,
    STS_EMPTY    = 3'd1,
    STS_FULL     = 3'd2,
    STS_FOUND    = 3'd3,
    STS_NOTFOUND = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_SHIFT_BACK,
    OP_SHIFT_FRONT,
    OP_LOAD,
    OP_MATCH,
    OP_SCAN
  } cell_op_e;

  typedef enum logic {
    FSM_IDLE,
    FSM_SCAN
  } state_e;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    cell_op_e                 op;
    logic signed [DATA_W-1:0] word;
  } cell_ctl_t;

endpackage

FILE: hw/rtl/dqs_if.sv
interface dqs_req_if
  import dqs_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [ACT_W-1:0]         action;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, action, value, input ready);
  modport sink (input valid, action, value, output ready);
endinterface

interface dqs_rsp_if
  import dqs_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [POS_W-1:0]     position;
  logic [CNT_OUT_W-1:0] count;

  modport source (output valid, status, position, count, input ready);
  modport sink (input valid, status, position, count, output ready);
endinterface

FILE: hw/rtl/dqs_cell.sv
module dqs_cell
  import dqs_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cell_ctl_t                ctl_i,
  input  logic                     sel_i,
  input  logic                     in_range_i,
  input  logic signed [DATA_W-1:0] front_data_i,
  input  logic signed [DATA_W-1:0] back_data_i,
  input  logic                     back_hit_i,
  output logic signed [DATA_W-1:0] data_o,
  output logic                     hit_o
);

  logic signed [DATA_W-1:0] data_d, data_q;
  logic                     hit_d, hit_q;

  always_comb begin
    data_d = data_q;
    hit_d  = 1'b0;
    case (ctl_i.op)
      OP_SHIFT_BACK:  data_d = front_data_i;
      OP_SHIFT_FRONT: data_d = back_data_i;
      OP_LOAD: begin
        if (sel_i) data_d = ctl_i.word;
      end
      OP_MATCH:       hit_d = in_range_i && (data_q == ctl_i.word);
      // Match flags move one place toward the front per scan step.
      OP_SCAN:        hit_d = back_hit_i;
      default:        hit_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  assign data_o = data_q;
  assign hit_o  = hit_q;

endmodule

FILE: hw/rtl/bounded_deque_with_search.sv
// Bounded double-ended queue of signed 32-bit words with value search.
// Requests arrive on req_i (action, value) and each one yields exactly one
// response on rsp_o (status, position, count), in request order.
// Entries live in a row of cells ordered front to back; pushes at the front
// and pops at the front shift every cell by one place in the same cycle.
// Push, pop, clear and unused actions need no scan: the response is valid
// on the cycle after the request is taken.
// A search compares every occupied cell in the cycle it is taken, then
// shifts the match flags toward the front one cell per cycle until the
// first hit reaches cell zero or the flag of the last occupied cell has
// been seen there without a hit. Searching an empty queue answers on the
// next cycle, like a pop.
// One request is in flight at a time; while no search is scanning, a new
// request is taken as soon as the response register is empty or draining.
// If the receiver stalls, the response holds and req_i.ready stays low.
// Reset empties the queue; no clearing pass is needed.
module bounded_deque_with_search
  import dqs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  dqs_req_if.sink    req_i,
  dqs_rsp_if.source  rsp_o
);

`include "assert_macros.svh"

  state_e               state_d, state_q;
  logic [CNT_W-1:0]     count_d, count_q;
  logic [IDX_W-1:0]     scan_d, scan_q;
  logic                 out_valid_q;
  logic [STATUS_W-1:0]  sts_q;
  logic [POS_W-1:0]     pos_q;
  logic [CNT_OUT_W-1:0] cnt_q;

  cell_ctl_t            ctl;
  logic                 ld_out;
  status_e              ld_sts;
  logic [POS_W-1:0]     ld_pos;
  logic                 req_fire;
  logic                 search_go;
  logic                 scan_last;
  logic                 scan_done;
  logic                 full;
  logic                 empty;
  act_e                 act;

  logic signed [DATA_W-1:0] data_w  [DEPTH];
  logic signed [DATA_W-1:0] front_w [DEPTH];
  logic signed [DATA_W-1:0] back_w  [DEPTH];
  logic                     hit_w   [DEPTH];
  logic                     bhit_w  [DEPTH];

  assign act       = act_e'(req_i.action);
  assign full      = (count_q == CNT_W'(DEPTH));
  assign empty     = (count_q == '0);
  assign req_i.ready = (state_q == FSM_IDLE) && (!out_valid_q || rsp_o.ready);
  assign req_fire  = req_i.valid && req_i.ready;
  assign search_go = req_fire && (act == ACT_SEARCH) && !empty;
  assign scan_last = (CNT_W'(scan_q) == count_q - CNT_W'(1));
  assign scan_done = (state_q == FSM_SCAN) && (hit_w[0] || scan_last);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE: begin
        if (search_go) state_d = FSM_SCAN;
      end
      FSM_SCAN: begin
        if (scan_done) state_d = FSM_IDLE;
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  // Cell commands, count update and response load.
  always_comb begin
    ctl.op   = OP_HOLD;
    ctl.word = req_i.value;
    count_d  = count_q;
    scan_d   = scan_q;
    ld_out   = 1'b0;
    ld_sts   = STS_OK;
    ld_pos   = '0;
    unique case (state_q)
      FSM_IDLE: begin
        if (req_fire) begin
          ld_out = 1'b1;
          case (act)
            ACT_PUSH_FRONT: begin
              if (full) begin
                ld_sts = STS_FULL;
              end else begin
                ctl.op  = OP_SHIFT_BACK;
                count_d = count_q + CNT_W'(1);
              end
            end
            ACT_PUSH_BACK: begin
              if (full) begin
                ld_sts = STS_FULL;
              end else begin
                ctl.op  = OP_LOAD;
                count_d = count_q + CNT_W'(1);
              end
            end
            ACT_POP_FRONT: begin
              if (empty) begin
                ld_sts = STS_EMPTY;
              end else begin
                ctl.op  = OP_SHIFT_FRONT;
                count_d = count_q - CNT_W'(1);
              end
            end
            ACT_POP_BACK: begin
              if (empty) ld_sts = STS_EMPTY;
              else count_d = count_q - CNT_W'(1);
            end
            ACT_CLEAR: count_d = '0;
            ACT_SEARCH: begin
              if (empty) begin
                ld_sts = STS_EMPTY;
              end else begin
                // The answer comes out of the scan instead.
                ld_out = 1'b0;
                ctl.op = OP_MATCH;
                scan_d = '0;
              end
            end
            default: ld_sts = STS_OK;
          endcase
        end
      end
      FSM_SCAN: begin
        if (hit_w[0]) begin
          ld_out = 1'b1;
          ld_sts = STS_FOUND;
          ld_pos = POS_W'(scan_q);
        end else if (scan_last) begin
          ld_out = 1'b1;
          ld_sts = STS_NOTFOUND;
        end else begin
          ctl.op = OP_SCAN;
          scan_d = scan_q + IDX_W'(1);
        end
      end
      default: ctl.op = OP_HOLD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      count_q     <= '0;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      scan_q  <= scan_d;
      if (ld_out) out_valid_q <= 1'b1;
      else if (rsp_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_out) begin
      sts_q <= ld_sts;
      pos_q <= ld_pos;
      cnt_q <= CNT_OUT_W'(count_d);
    end
  end

  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.status   = sts_q;
  assign rsp_o.position = pos_q;
  assign rsp_o.count    = cnt_q;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign front_w[i] = ctl.word;
    end else begin : g_mid
      assign front_w[i] = data_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign back_w[i] = '0;
      assign bhit_w[i] = 1'b0;
    end else begin : g_body
      assign back_w[i] = data_w[i+1];
      assign bhit_w[i] = hit_w[i+1];
    end

    dqs_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .sel_i        (CNT_W'(i) == count_q),
      .in_range_i   (CNT_W'(i) < count_q),
      .front_data_i (front_w[i]),
      .back_data_i  (back_w[i]),
      .back_hit_i   (bhit_w[i]),
      .data_o       (data_w[i]),
      .hit_o        (hit_w[i])
    );
  end

  `DQS_ASSERT(a_count_bound, count_q <= CNT_W'(DEPTH), "entry count above depth")
  `DQS_ASSERT_IMPL(a_scan_out_free, state_q == FSM_SCAN, !out_valid_q,
                   "response register busy during a search scan")
  `DQS_ASSERT_NEXT(a_quick_resp, req_fire && !search_go, out_valid_q,
                   "single-cycle request gave no response")
  `DQS_ASSERT_IMPL(a_found_pos, out_valid_q && sts_q == STS_FOUND,
                   CNT_OUT_W'(pos_q) < cnt_q, "found position outside occupancy")
  `DQS_ASSERT_IMPL(a_scan_range, state_q == FSM_SCAN,
                   CNT_W'(scan_q) < count_q, "scan index beyond occupancy")

endmodule

FILE: dv/bounded_deque_with_search_tb.sv
module bounded_deque_with_search_tb
  import dqs_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ACT_W-1:0] ACT_UNUSED_A = 3'd6;
  localparam logic [ACT_W-1:0] ACT_UNUSED_B = 3'd7;

  localparam int RANDOM_PER_PHASE = 325;
  localparam int CYCLE_LIMIT      = 500000;
  localparam int DRAIN_CYCLES     = 2 * DEPTH + 8;
  localparam int MAX_PRINTS       = 40;

  typedef struct packed {
    status_e              status;
    logic [POS_W-1:0]     position;
    logic [CNT_OUT_W-1:0] count;
  } deque_rsp_t;

  typedef struct {
    logic [ACT_W-1:0]  act;
    logic [DATA_W-1:0] val;
    int                reps;
    bit                typed;
    status_e           status;
    int                position;
    int                count;
  } directed_row_t;

  localparam int N_DIRECTED = 16;

  // Rows with typed set carry their expected response, worked out from the rows before them.
  directed_row_t directed_rows [N_DIRECTED] = '{
    '{ACT_POP_FRONT,  32'h0000_0000, 1,  1, STS_EMPTY,    0,  0},
    '{ACT_SEARCH,     32'h0000_0000, 1,  1, STS_EMPTY,    0,  0},
    '{ACT_PUSH_BACK,  32'h8000_0000, 1,  1, STS_OK,       0,  1},
    '{ACT_PUSH_FRONT, 32'h7FFF_FFFF, 1,  1, STS_OK,       0,  2},
    '{ACT_PUSH_BACK,  32'h0000_0001, 13, 0, STS_OK,       0,  0},
    '{ACT_PUSH_BACK,  32'h0000_0000, 1,  1, STS_OK,       0, 16},
    '{ACT_PUSH_FRONT, 32'h1234_5678, 1,  1, STS_FULL,     0, 16},
    '{ACT_PUSH_BACK,  32'hFFFF_FFFF, 1,  1, STS_FULL,     0, 16},
    '{ACT_SEARCH,     32'h0000_0000, 1,  1, STS_FOUND,   15, 16},
    '{ACT_SEARCH,     32'h8000_0000, 1,  1, STS_FOUND,    1, 16},
    '{ACT_SEARCH,     32'hFFFF_FFFF, 1,  1, STS_NOTFOUND, 0, 16},
    '{ACT_UNUSED_A,   32'h5555_5555, 1,  1, STS_OK,       0, 16},
    '{ACT_UNUSED_B,   32'hAAAA_AAAA, 1,  1, STS_OK,       0, 16},
    '{ACT_POP_FRONT,  32'h0000_0000, 1,  1, STS_OK,       0, 15},
    '{ACT_POP_BACK,   32'h0000_0000, 1,  1, STS_OK,       0, 14},
    '{ACT_CLEAR,      32'hFFFF_FFFF, 1,  1, STS_OK,       0,  0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  dqs_req_if req_bus ();
  dqs_rsp_if rsp_bus ();

  bounded_deque_with_search dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  logic signed [DATA_W-1:0] deque_contents[$];
  deque_rsp_t               pending_rsp_q[$];

  int send_idle_pct;
  int recv_stall_pct;
  int cycle_count;
  int mismatch_count;
  int request_count;
  int search_count;
  int hit_count;
  int full_reject_count;
  int empty_count;
  int burst_left;
  bit burst_fill;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic report_mismatch(string what);
    if (mismatch_count < MAX_PRINTS) begin
      $display("ERROR cycle %0d: %s", cycle_count, what);
    end
    mismatch_count++;
  endtask

  // Applies one request to the shadow deque and returns the response it earns.
  function automatic deque_rsp_t apply_request(logic [ACT_W-1:0] act,
                                               logic signed [DATA_W-1:0] val);
    deque_rsp_t rsp;
    bit         hit;
    rsp.status   = STS_OK;
    rsp.position = '0;
    hit          = 1'b0;
    case (act)
      ACT_PUSH_FRONT: begin
        if (deque_contents.size() >= DEPTH) rsp.status = STS_FULL;
        else deque_contents.push_front(val);
      end
      ACT_PUSH_BACK: begin
        if (deque_contents.size() >= DEPTH) rsp.status = STS_FULL;
        else deque_contents.push_back(val);
      end
      ACT_POP_FRONT: begin
        if (deque_contents.size() == 0) rsp.status = STS_EMPTY;
        else void'(deque_contents.pop_front());
      end
      ACT_POP_BACK: begin
        if (deque_contents.size() == 0) rsp.status = STS_EMPTY;
        else void'(deque_contents.pop_back());
      end
      ACT_CLEAR: begin
        deque_contents.delete();
      end
      ACT_SEARCH: begin
        if (deque_contents.size() == 0) begin
          rsp.status = STS_EMPTY;
        end else begin
          rsp.status = STS_NOTFOUND;
          for (int i = 0; i < deque_contents.size(); i++) begin
            if (!hit && deque_contents[i] === val) begin
              hit          = 1'b1;
              rsp.status   = STS_FOUND;
              rsp.position = POS_W'(i);
            end
          end
        end
      end
      default: ;
    endcase
    rsp.count = CNT_OUT_W'(deque_contents.size());
    return rsp;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    logic signed [DATA_W-1:0] val;
    case ($urandom_range(9))
      0, 1, 2, 3: val = $urandom;
      8:          val = 32'sh8000_0000;
      9:          val = 32'sh7FFF_FFFF;
      // A narrow pool makes repeated entries, so a search must pick the first one.
      default:    val = $signed(DATA_W'($urandom_range(7))) - 4;
    endcase
    return val;
  endfunction

  task automatic next_request(output logic [ACT_W-1:0] act,
                              output logic signed [DATA_W-1:0] val);
    int roll;
    roll = $urandom_range(99);
    val  = pick_value();
    if (burst_left == 0) begin
      if (roll < 4) begin
        burst_left = DEPTH + $urandom_range(1, 3);
        burst_fill = 1'b1;
      end else if (roll < 7) begin
        burst_left = DEPTH + $urandom_range(1, 3);
        burst_fill = 1'b0;
      end
    end
    if (burst_left != 0) begin
      burst_left--;
      if (burst_fill) act = $urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
      else act = $urandom_range(1) ? ACT_POP_BACK : ACT_POP_FRONT;
    end else begin
      roll = $urandom_range(99);
      if (roll < 30) act = $urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
      else if (roll < 55) act = $urandom_range(1) ? ACT_POP_BACK : ACT_POP_FRONT;
      else if (roll < 93) act = ACT_SEARCH;
      else if (roll < 96) act = ACT_CLEAR;
      else act = $urandom_range(1) ? ACT_UNUSED_B : ACT_UNUSED_A;
      if (act == ACT_SEARCH && deque_contents.size() != 0 && $urandom_range(2) != 0) begin
        val = deque_contents[$urandom_range(deque_contents.size() - 1)];
      end
    end
  endtask

  // Drives one request, waits for the handshake and records its expected response.
  // Valid is left high on acceptance so back-to-back requests need no extra edge.
  task automatic send_request(logic [ACT_W-1:0] act, logic signed [DATA_W-1:0] val,
                              bit typed, deque_rsp_t typed_rsp);
    deque_rsp_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_bus.valid  <= 1'b1;
    req_bus.action <= act;
    req_bus.value  <= val;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    predicted = apply_request(act, val);
    pending_rsp_q.push_back(typed ? typed_rsp : predicted);
    request_count++;
    if (act == ACT_SEARCH) search_count++;
    if (predicted.status == STS_FOUND) hit_count++;
    if (predicted.status == STS_FULL) full_reject_count++;
    if (predicted.status == STS_EMPTY) empty_count++;
  endtask

  always @(posedge clk_i) begin
    rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    deque_rsp_t want;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_rsp_q.size() == 0) begin
        report_mismatch($sformatf("response with no request pending (status %0d)",
                                  rsp_bus.status));
      end else begin
        want = pending_rsp_q.pop_front();
        if (rsp_bus.status !== want.status) begin
          report_mismatch($sformatf("status %0d, expected %0d", rsp_bus.status, want.status));
        end
        if (rsp_bus.position !== want.position) begin
          report_mismatch($sformatf("position %0d, expected %0d",
                                    rsp_bus.position, want.position));
        end
        if (rsp_bus.count !== want.count) begin
          report_mismatch($sformatf("count %0d, expected %0d", rsp_bus.count, want.count));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d responses outstanding",
               cycle_count, pending_rsp_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    logic [ACT_W-1:0]         act;
    logic signed [DATA_W-1:0] val;
    deque_rsp_t               typed_rsp;
    deque_rsp_t               no_rsp;
    no_rsp            = '{STS_OK, '0, '0};
    rst_ni            = 1'b0;
    req_bus.valid     = 1'b0;
    req_bus.action    = ACT_CLEAR;
    req_bus.value     = '0;
    rsp_bus.ready     = 1'b0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    cycle_count       = 0;
    mismatch_count    = 0;
    request_count     = 0;
    search_count      = 0;
    hit_count         = 0;
    full_reject_count = 0;
    empty_count       = 0;
    burst_left        = 0;
    burst_fill        = 1'b0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      typed_rsp.status   = directed_rows[r].status;
      typed_rsp.position = POS_W'(directed_rows[r].position);
      typed_rsp.count    = CNT_OUT_W'(directed_rows[r].count);
      repeat (directed_rows[r].reps) begin
        send_request(directed_rows[r].act, directed_rows[r].val, directed_rows[r].typed,
                     typed_rsp);
      end
    end

    // Handshake phases: free flow, sparse requests, slow receiver, light jitter on both.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      repeat (RANDOM_PER_PHASE) begin
        next_request(act, val);
        send_request(act, val, 1'b0, no_rsp);
      end
    end
    req_bus.valid <= 1'b0;

    while (pending_rsp_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d requests over four handshake phases: %0d searches (%0d hits),",
             request_count, search_count, hit_count);
    $display("%0d pushes rejected as full, %0d empty answers, %0d mismatches.",
             full_reject_count, empty_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
